>>> rtl/core/forbu_pkg.sv
// ----------------------------------------------------------------------------
// forbu_pkg
// Shared types, constants and helpers of the frame-of-reference bit unpacker.
// ----------------------------------------------------------------------------
package forbu_pkg;

   localparam int ROW_INDEX_BITS = 20;
   localparam int VALUE_BITS     = 64;
   localparam int OFFSET_BITS    = 32;
   localparam int BUFFER_BITS    = 39;
   localparam int RSP_DATA_BITS  = ((VALUE_BITS + ROW_INDEX_BITS + 7) / 8) * 8;

   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

   localparam logic [3:0] MAX_PLAIN_BYTES  = 4'd4;
   localparam logic [3:0] MAX_FOR_BYTES    = 4'd8;
   localparam logic [5:0] MAX_OFFSET_WIDTH = 6'd32;
   localparam logic [2:0] LAST_RESULT_NUM  = 3'd7;   // at most eight values per beat

   localparam logic [ROW_INDEX_BITS-1:0] ROW_ONE = 1;

   // register indexes
   localparam logic [2:0] REG_MODE         = 3'd0;
   localparam logic [2:0] REG_VALUE_BYTES  = 3'd1;
   localparam logic [2:0] REG_OFFSET_WIDTH = 3'd2;
   localparam logic [2:0] REG_BASE         = 3'd3;
   localparam logic [2:0] REG_BLOCK_ROWS   = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK                = 2'd0;
   localparam logic [1:0] ST_BAD_VALUE_SIZE    = 2'd1;
   localparam logic [1:0] ST_BAD_OFFSET_WIDTH  = 2'd2;

   typedef struct packed {
      logic                      mode;
      logic [3:0]                value_bytes;
      logic [5:0]                offset_width;
      logic [VALUE_BITS-1:0]     base;
      logic [ROW_INDEX_BITS-1:0] block_rows;
   } cfg_type;

   // one queued result job
   typedef struct packed {
      logic [OFFSET_BITS-1:0]    offset;
      logic [ROW_INDEX_BITS-1:0] row_index;
      logic                      last;
      logic [1:0]                status;
   } job_type;

   function automatic logic [VALUE_BITS-1:0] bytes_mask(input logic [3:0] nbytes);
      logic [VALUE_BITS-1:0] m;
      if (nbytes >= 4'd8) begin
         m = '1;
      end else begin
         m = ({{(VALUE_BITS-1){1'b0}}, 1'b1} << {nbytes[2:0], 3'b000})
             - {{(VALUE_BITS-1){1'b0}}, 1'b1};
      end
      return m;
   endfunction

endpackage

>>> rtl/core/forbu_fifo.sv
// ----------------------------------------------------------------------------
// forbu_fifo
// Small job queue between the bit gatherer and the value stage.
// ----------------------------------------------------------------------------
module forbu_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  forbu_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output forbu_pkg::job_type pop_job,
   output logic               empty
);

   forbu_pkg::job_type mem [forbu_pkg::FIFO_DEPTH];

   logic [forbu_pkg::FIFO_PTR_BITS-1:0] wptr_ff, wptr_in;
   logic [forbu_pkg::FIFO_PTR_BITS-1:0] rptr_ff, rptr_in;
   logic [forbu_pkg::FIFO_CNT_BITS-1:0] count_ff, count_in;

   assign full    = (count_ff == forbu_pkg::FIFO_CNT_BITS'(forbu_pkg::FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = mem[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/forbu_front.sv
// ----------------------------------------------------------------------------
// forbu_front
// Takes payload beats, checks widths, gathers bits and cuts offsets into the
// job queue, one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module forbu_front (
   input  logic               clock,
   input  logic               reset,
   input  forbu_pkg::cfg_type cfg,
   input  logic               clear_stream,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               fifo_full,
   output logic               push,
   output forbu_pkg::job_type push_job
);

   logic [forbu_pkg::BUFFER_BITS-1:0]    bitbuf_ff, bitbuf_in;
   logic [5:0]                           held_ff, held_in;
   logic [forbu_pkg::ROW_INDEX_BITS-1:0] rows_ff, rows_in;
   logic                                 busy_ff, busy_in;
   logic [2:0]                           nres_ff, nres_in;

   logic                                 accept;
   logic                                 bad_vb;
   logic                                 bad_bw;
   logic [1:0]                           status;
   logic                                 more_rows;
   logic                                 active;
   logic                                 err_push;
   logic [forbu_pkg::BUFFER_BITS-1:0]    work_buf;
   logic [forbu_pkg::BUFFER_BITS-1:0]    width_mask;
   logic [forbu_pkg::BUFFER_BITS-1:0]    shifted;
   logic [5:0]                           work_held;
   logic [5:0]                           left_held;
   logic [2:0]                           work_n;
   logic                                 emit;
   logic                                 last_one;

   always_comb begin
      bad_vb = (cfg.value_bytes == 4'd0) ||
               (cfg.value_bytes > (cfg.mode ? forbu_pkg::MAX_FOR_BYTES
                                            : forbu_pkg::MAX_PLAIN_BYTES));
      bad_bw = (cfg.offset_width == 6'd0) ||
               (cfg.offset_width > forbu_pkg::MAX_OFFSET_WIDTH);
      if (bad_vb) begin
         status = forbu_pkg::ST_BAD_VALUE_SIZE;
      end else if (bad_bw) begin
         status = forbu_pkg::ST_BAD_OFFSET_WIDTH;
      end else begin
         status = forbu_pkg::ST_OK;
      end

      req_tready = !busy_ff && !fifo_full;
      accept     = req_tvalid && req_tready;
      more_rows  = rows_ff < cfg.block_rows;
      err_push   = accept && (status != forbu_pkg::ST_OK);

      // busy: keep cutting offsets out of what is held; else merge the new beat
      if (busy_ff) begin
         work_buf  = bitbuf_ff;
         work_held = held_ff;
         work_n    = nres_ff;
         active    = !fifo_full;
      end else begin
         work_buf  = bitbuf_ff |
                     ({{(forbu_pkg::BUFFER_BITS-8){1'b0}}, req_tdata} << held_ff[4:0]);
         work_held = held_ff + 6'd8;
         work_n    = 3'd0;
         active    = accept && (status == forbu_pkg::ST_OK) && more_rows;
      end

      width_mask = ({{(forbu_pkg::BUFFER_BITS-1){1'b0}}, 1'b1} << cfg.offset_width)
                   - {{(forbu_pkg::BUFFER_BITS-1){1'b0}}, 1'b1};
      shifted    = work_buf >> cfg.offset_width;
      left_held  = work_held - cfg.offset_width;
      emit       = active && (work_held >= cfg.offset_width) && more_rows;
      last_one   = (left_held < cfg.offset_width) ||
                   ((rows_ff + forbu_pkg::ROW_ONE) >= cfg.block_rows) ||
                   (work_n == forbu_pkg::LAST_RESULT_NUM);

      push               = emit || err_push;
      push_job.offset    = work_buf[forbu_pkg::OFFSET_BITS-1:0] &
                           width_mask[forbu_pkg::OFFSET_BITS-1:0];
      push_job.row_index = rows_ff;
      push_job.last      = err_push ? 1'b1 : last_one;
      push_job.status    = err_push ? status : forbu_pkg::ST_OK;

      bitbuf_in = bitbuf_ff;
      held_in   = held_ff;
      rows_in   = rows_ff;
      busy_in   = busy_ff;
      nres_in   = nres_ff;
      if (clear_stream) begin
         bitbuf_in = '0;
         held_in   = '0;
         rows_in   = '0;
         busy_in   = 1'b0;
         nres_in   = '0;
      end else if (active) begin
         bitbuf_in = emit ? shifted : work_buf;
         held_in   = emit ? left_held : work_held;
         rows_in   = emit ? rows_ff + forbu_pkg::ROW_ONE : rows_ff;
         busy_in   = emit && !last_one;
         nres_in   = work_n + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitbuf_ff <= '0;
         held_ff   <= '0;
         rows_ff   <= '0;
         busy_ff   <= 1'b0;
         nres_ff   <= '0;
      end else begin
         bitbuf_ff <= bitbuf_in;
         held_ff   <= held_in;
         rows_ff   <= rows_in;
         busy_ff   <= busy_in;
         nres_ff   <= nres_in;
      end
   end

endmodule

>>> rtl/core/forbu_back.sv
// ----------------------------------------------------------------------------
// forbu_back
// Pops jobs, adds the base in frame-of-reference mode, truncates to
// value_bytes and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module forbu_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  forbu_pkg::cfg_type                   cfg,
   input  logic                                 fifo_empty,
   input  forbu_pkg::job_type                   pop_job,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [forbu_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                 rsp_tlast,
   output logic [1:0]                           rsp_tuser
);

   logic                                 valid_ff, valid_in;
   logic [forbu_pkg::VALUE_BITS-1:0]     value_ff, value_in;
   logic [forbu_pkg::ROW_INDEX_BITS-1:0] row_ff;
   logic                                 last_ff;
   logic [1:0]                           status_ff;
   logic [forbu_pkg::VALUE_BITS-1:0]     wide_offset;

   always_comb begin
      pop         = !fifo_empty && (!valid_ff || rsp_tready);
      wide_offset = {{(forbu_pkg::VALUE_BITS-forbu_pkg::OFFSET_BITS){1'b0}}, pop_job.offset};
      if (pop_job.status != forbu_pkg::ST_OK) begin
         value_in = '0;
      end else begin
         value_in = (cfg.mode ? cfg.base + wide_offset : wide_offset) &
                    forbu_pkg::bytes_mask(cfg.value_bytes);
      end
      valid_in = pop || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         value_ff  <= value_in;
         row_ff    <= pop_job.row_index;
         last_ff   <= pop_job.last;
         status_ff <= pop_job.status;
      end
   end

   always_comb begin
      rsp_tvalid = valid_ff;
      rsp_tdata  = '0;
      rsp_tdata[forbu_pkg::VALUE_BITS-1:0] = value_ff;
      rsp_tdata[forbu_pkg::VALUE_BITS +: forbu_pkg::ROW_INDEX_BITS] = row_ff;
      rsp_tlast  = last_ff;
      rsp_tuser  = status_ff;
   end

endmodule

>>> rtl/core/frame_of_reference_bit_unpacker.sv
// ----------------------------------------------------------------------------
// frame_of_reference_bit_unpacker
// Unpacks a bit-packed / frame-of-reference payload into values.
// ----------------------------------------------------------------------------
// Usage:
//   Software parses the block header and writes mode, value_bytes, offset
//   width, base and the block row count over the csr_ port; writing the row
//   count starts a block. Payload bytes then arrive one per beat on req_
//   (req_tdata = packed_byte), bits taken LSB first. Every offset-width bits
//   give one result beat on rsp_ (value, row index), rsp_tlast marking the
//   final result of an input beat. Once the row count is reached, padding
//   beats are taken and dropped. A bad value_bytes or offset width gives one
//   zero-valued error beat per input beat.
// Timing:
//   The front writes a result's job into the queue at the edge that accepts
//   its input beat, and the back loads the output register from the queue
//   once that register is free. The front cuts one offset per cycle while
//   the queue has room and takes no new beat until it has cut every offset
//   of the last one: one beat per cycle for widths of 8 and up.
// Reset and stall:
//   Reset restores register defaults and empties the stream state and queue.
//   A stalled receiver holds the output register; the 4-deep job queue fills
//   and then req_tready drops until space frees up.
// ----------------------------------------------------------------------------
module frame_of_reference_bit_unpacker (
   input  logic                                 clock,
   input  logic                                 reset,
   // config write port
   input  logic                                 csr_we,
   input  logic [2:0]                           csr_index,
   input  logic [63:0]                          csr_wdata,
   // payload beats
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] packed_byte
   // result beats
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [forbu_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,   // [63:0] value,
                                                             // [83:64] row_index, pad
   output logic                                 rsp_tlast,
   output logic [1:0]                           rsp_tuser    // [1:0] status
);

   forbu_pkg::cfg_type cfg_ff, cfg_in;
   logic               clear_stream;

   // queue hookup
   logic               push;
   logic               pop;
   logic               fifo_full;
   logic               fifo_empty;
   forbu_pkg::job_type push_job;
   forbu_pkg::job_type pop_job;

   // register writes; unknown indexes are dropped
   always_comb begin
      cfg_in       = cfg_ff;
      clear_stream = 1'b0;
      if (csr_we) begin
         case (csr_index)
            forbu_pkg::REG_MODE: begin
               cfg_in.mode = csr_wdata[0];
            end
            forbu_pkg::REG_VALUE_BYTES: begin
               cfg_in.value_bytes = csr_wdata[3:0];
            end
            forbu_pkg::REG_OFFSET_WIDTH: begin
               cfg_in.offset_width = csr_wdata[5:0];
            end
            forbu_pkg::REG_BASE: begin
               cfg_in.base = csr_wdata;
            end
            forbu_pkg::REG_BLOCK_ROWS: begin
               cfg_in.block_rows = csr_wdata[forbu_pkg::ROW_INDEX_BITS-1:0];
               clear_stream      = 1'b1;   // new block
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= 1'b0;
         cfg_ff.value_bytes  <= 4'd4;
         cfg_ff.offset_width <= 6'd8;
         cfg_ff.base         <= '0;
         cfg_ff.block_rows   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: width checks, bit gathering, offset cutting
   forbu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .clear_stream (clear_stream),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .fifo_full    (fifo_full),
      .push         (push),
      .push_job     (push_job)
   );

   // decouples the gatherer from the output stall
   forbu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (fifo_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (fifo_empty)
   );

   // back: base add, truncation, output register
   forbu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_empty (fifo_empty),
      .pop_job    (pop_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> dv/unpack_checker.sv
// ----------------------------------------------------------------------------
// unpack_checker
// Watches the register port and both streams of the bit unpacker, predicts
// the values that each accepted payload beat yields and compares each
// result beat, field by field, with the oldest expected value.
// ----------------------------------------------------------------------------
module unpack_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [2:0]                          csr_index,
   input  logic [63:0]                         csr_wdata,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [forbu_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                                rsp_tlast,
   input  logic [1:0]                          rsp_tuser,
   output int unsigned                         mismatch_count,
   output int unsigned                         values_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [forbu_pkg::VALUE_BITS-1:0]     value;
      logic [forbu_pkg::ROW_INDEX_BITS-1:0] row_index;
      logic                                 last;
      logic [1:0]                           status;
   } unpacked_value_type;

   forbu_pkg::cfg_type                   regs;
   logic [63:0]                          bit_store;
   logic [5:0]                           bits_in_store;
   logic [forbu_pkg::ROW_INDEX_BITS-1:0] rows_out;
   unpacked_value_type                   expected_values[$];
   int unsigned                          errors;

   initial begin
      mismatch_count = 0;
      values_pending = 0;
      errors         = 0;
   end

   // Turns one payload byte into the values it completes.
   task automatic unpack_byte(input logic [7:0] data);
      logic [3:0]                        byte_limit;
      logic [1:0]                        err;
      logic [forbu_pkg::VALUE_BITS-1:0]  keep_mask;
      logic [forbu_pkg::OFFSET_BITS-1:0] offset;
      logic [forbu_pkg::VALUE_BITS-1:0]  sum;
      unpacked_value_type                held;
      bit                                have_held;
      int                                n;
      byte_limit = regs.mode ? forbu_pkg::MAX_FOR_BYTES : forbu_pkg::MAX_PLAIN_BYTES;
      keep_mask  = (regs.value_bytes >= 4'd8) ? {forbu_pkg::VALUE_BITS{1'b1}} :
                   ~({forbu_pkg::VALUE_BITS{1'b1}} << {regs.value_bytes[2:0], 3'b000});
      have_held  = 1'b0;
      held       = '0;
      n          = 0;
      err        = forbu_pkg::ST_OK;
      if (regs.value_bytes == 4'd0 || regs.value_bytes > byte_limit) begin
         err = forbu_pkg::ST_BAD_VALUE_SIZE;
      end else if (regs.offset_width == 6'd0 ||
                   regs.offset_width > forbu_pkg::MAX_OFFSET_WIDTH) begin
         err = forbu_pkg::ST_BAD_OFFSET_WIDTH;
      end
      if (err != forbu_pkg::ST_OK) begin
         // bad geometry: one zero beat, stream state untouched
         held.value     = '0;
         held.row_index = rows_out;
         held.last      = 1'b1;
         held.status    = err;
         expected_values.insert(expected_values.size(), held);
      end else if (rows_out < regs.block_rows) begin
         bit_store     = bit_store | ({56'd0, data} << bits_in_store[4:0]);
         bits_in_store = bits_in_store + 6'd8;
         while (bits_in_store >= regs.offset_width && rows_out < regs.block_rows &&
                n < 8) begin
            offset = bit_store[forbu_pkg::OFFSET_BITS-1:0] &
                     ~({forbu_pkg::OFFSET_BITS{1'b1}} << regs.offset_width);
            sum    = regs.mode ? regs.base + {32'd0, offset} : {32'd0, offset};
            bit_store     = bit_store >> regs.offset_width;
            bits_in_store = bits_in_store - regs.offset_width;
            if (have_held) expected_values.insert(expected_values.size(), held);
            held.value     = sum & keep_mask;
            held.row_index = rows_out;
            held.last      = 1'b0;
            held.status    = forbu_pkg::ST_OK;
            have_held      = 1'b1;
            rows_out       = rows_out + forbu_pkg::ROW_ONE;
            n++;
         end
         if (have_held) begin
            held.last = 1'b1;
            expected_values.insert(expected_values.size(), held);
         end
      end
   endtask

   always @(posedge clock) begin
      unpacked_value_type got;
      unpacked_value_type want;
      if (reset) begin
         regs.mode         = 1'b0;
         regs.value_bytes  = forbu_pkg::MAX_PLAIN_BYTES;
         regs.offset_width = 6'd8;
         regs.base         = '0;
         regs.block_rows   = '0;
         bit_store         = '0;
         bits_in_store     = '0;
         rows_out          = '0;
         expected_values.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               forbu_pkg::REG_MODE:         regs.mode         = csr_wdata[0];
               forbu_pkg::REG_VALUE_BYTES:  regs.value_bytes  = csr_wdata[3:0];
               forbu_pkg::REG_OFFSET_WIDTH: regs.offset_width = csr_wdata[5:0];
               forbu_pkg::REG_BASE:         regs.base         = csr_wdata;
               forbu_pkg::REG_BLOCK_ROWS: begin
                  regs.block_rows = csr_wdata[forbu_pkg::ROW_INDEX_BITS-1:0];
                  bit_store       = '0;
                  bits_in_store   = '0;
                  rows_out        = '0;
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) unpack_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.value     = rsp_tdata[forbu_pkg::VALUE_BITS-1:0];
            got.row_index = rsp_tdata[forbu_pkg::VALUE_BITS +: forbu_pkg::ROW_INDEX_BITS];
            got.last      = rsp_tlast;
            got.status    = rsp_tuser;
            if (expected_values.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat value %h row %0d last %b status %0d",
                        $time, got.value, got.row_index, got.last, got.status);
            end else begin
               want = expected_values.pop_front();
               if (got.value !== want.value || got.row_index !== want.row_index ||
                   got.last !== want.last || got.status !== want.status) begin
                  errors++;
                  $display("%0t: expected value %h row %0d last %b status %0d", $time,
                           want.value, want.row_index, want.last, want.status);
                  $display("%0t:   actual value %h row %0d last %b status %0d", $time,
                           got.value, got.row_index, got.last, got.status);
               end
            end
         end
      end
      mismatch_count <= errors;
      values_pending <= expected_values.size();
   end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the frame-of-reference bit unpacker: register setup between blocks,
// payload beats with random gaps, a randomly stalling result side. A checker
// beside the block predicts and compares; this module only makes stimulus
// and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_PERIOD_NS     = 4;
   localparam int          RESET_CYCLES        = 8;
   localparam int          LONG_HOLD_CYCLES    = 60;   // receiver hold-off, fills the job queue
   localparam int          DRAIN_SETTLE_CYCLES = 16;   // settle time for the output register and the front's last beat
   localparam int unsigned RANDOM_BEATS        = 140;  // payload beats of random blocks, padding not counted
   localparam int unsigned CYCLE_LIMIT         = 500000;
   // indexes past the last register: writes there must be dropped
   localparam logic [2:0]  REG_UNUSED_FIRST    = forbu_pkg::REG_BLOCK_ROWS + 3'd1;
   localparam logic [forbu_pkg::ROW_INDEX_BITS-1:0] BLOCK_ROWS_MAX = '1;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                csr_we     = 1'b0;
   logic [2:0]                          csr_index  = forbu_pkg::REG_MODE;
   logic [63:0]                         csr_wdata  = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [7:0]                          req_tdata  = '0;   // [7:0] packed_byte
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [forbu_pkg::RSP_DATA_BITS-1:0] rsp_tdata;   // [63:0] value, [83:64] row_index, pad
   logic                                rsp_tlast;
   logic [1:0]                          rsp_tuser;   // [1:0] status

   logic                                hold_request = 1'b0;  // toggled to ask for a long hold-off
   logic                                hold_ack     = 1'b0;  // follows hold_request once it starts
   int unsigned                         mismatch_count;
   int unsigned                         values_pending;
   int unsigned                         payload_beats = 0;
   int unsigned                         cycle_count   = 0;

   always #(CLOCK_PERIOD_NS / 2.0) clock = ~clock;

   frame_of_reference_bit_unpacker i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   unpack_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .values_pending (values_pending)
   );

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result side. Short stalls are common, long ones rare, and now and then
   // a stretch of steady ready. A toggle of hold_request buys one long
   // hold-off, counted here, while the sender keeps offering beats.
   initial begin : result_side
      logic        hold_seen;
      int unsigned roll;
      hold_seen = 1'b0;
      forever begin
         roll = $urandom_range(0, 99);
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_ack   <= hold_seen;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (roll < 8) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(30, 80)) @(posedge clock);
         end else if (roll < 38) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if (roll < 41) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(10, 30)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // One register write; the task returns with the write enable low again.
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one payload beat until taken. tvalid only drops when a gap
   // follows, so back-to-back beats never lower and raise it in one step.
   task automatic send_byte(input logic [7:0] data, input int unsigned gap);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender quiet until every expected value is out, then let the front
   // finish any beat that yields nothing.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (values_pending != 0);
      repeat (DRAIN_SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned pick_gap(input bit steady);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_base();
      case ($urandom_range(0, 3))
         0:       return '1;
         1:       return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // One block with a random header. Mostly well-formed geometry sized to
   // a handful of beats; some blocks carry a bad value or offset width, some
   // a huge row count, some a width change halfway through.
   task automatic random_block();
      logic                                 mode;
      logic [3:0]                           vbytes;
      logic [5:0]                           width;
      logic [forbu_pkg::ROW_INDEX_BITS-1:0] rows;
      int unsigned                          pick, nbytes, pad, split, i;
      bit                                   steady, faulty;
      pick   = $urandom_range(0, 99);
      mode   = 1'($urandom_range(0, 1));
      steady = ($urandom_range(0, 3) == 0);
      faulty = (pick < 15);

      if (pick < 8) begin
         vbytes = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(mode ? 9 : 5, 15));
      end else if ($urandom_range(0, 3) == 0) begin
         vbytes = mode ? forbu_pkg::MAX_FOR_BYTES : forbu_pkg::MAX_PLAIN_BYTES;
      end else begin
         vbytes = 4'($urandom_range(1, mode ? 8 : 4));
      end

      if (pick >= 8 && pick < 15) begin
         width = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
      end else begin
         case ($urandom_range(0, 5))
            0:       width = 6'd1;
            1:       width = forbu_pkg::MAX_OFFSET_WIDTH;
            2:       width = 6'd8;
            default: width = 6'($urandom_range(1, 32));
         endcase
      end

      pad = 0;
      if (faulty) begin
         rows   = forbu_pkg::ROW_INDEX_BITS'($urandom_range(1, 20));
         nbytes = $urandom_range(1, 4);
      end else if ($urandom_range(0, 19) == 0) begin
         rows   = BLOCK_ROWS_MAX;   // block never completes within the beats sent
         nbytes = $urandom_range(4, 12);
      end else begin
         rows   = forbu_pkg::ROW_INDEX_BITS'($urandom_range(1, 160 / width));
         nbytes = (int'(rows) * width + 7) / 8;
         pad    = $urandom_range(0, 2);
      end

      write_reg(forbu_pkg::REG_MODE, {63'd0, mode});
      write_reg(forbu_pkg::REG_VALUE_BYTES, {60'd0, vbytes});
      write_reg(forbu_pkg::REG_OFFSET_WIDTH, {58'd0, width});
      write_reg(forbu_pkg::REG_BASE, pick_base());
      if ($urandom_range(0, 4) == 0) begin
         write_reg(REG_UNUSED_FIRST + 3'($urandom_range(0, 2)), {$urandom, $urandom});
      end
      write_reg(forbu_pkg::REG_BLOCK_ROWS, {44'd0, rows});

      split = (!faulty && nbytes >= 4 && $urandom_range(0, 3) == 0) ? nbytes / 2 : nbytes;
      for (i = 0; i < nbytes + pad; i++) begin
         if (i == split && split != nbytes) begin
            // mid-block: new width and sometimes a new base, held bits are read at the new width
            drain();
            write_reg(forbu_pkg::REG_OFFSET_WIDTH, {58'd0, 6'($urandom_range(1, 32))});
            if ($urandom_range(0, 1) == 0) write_reg(forbu_pkg::REG_BASE, pick_base());
         end
         send_byte(pick_byte(), pick_gap(steady));
      end
      payload_beats += nbytes;   // padding beats are dropped, not counted
      drain();
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset leaves the row count at zero: the block is already complete
      // and a payload beat gives nothing.
      send_byte(8'h00, 0);
      drain();

      // Widest plain offset, all ones, then a padding beat.
      write_reg(forbu_pkg::REG_MODE, 64'd0);
      write_reg(forbu_pkg::REG_VALUE_BYTES, {60'd0, forbu_pkg::MAX_PLAIN_BYTES});
      write_reg(forbu_pkg::REG_OFFSET_WIDTH, {58'd0, forbu_pkg::MAX_OFFSET_WIDTH});
      write_reg(forbu_pkg::REG_BLOCK_ROWS, 64'd1);
      repeat (5) send_byte(8'hFF, 0);
      drain();

      // Frame of reference, 8-byte values, base all ones: base + 2 wraps.
      write_reg(forbu_pkg::REG_MODE, 64'd1);
      write_reg(forbu_pkg::REG_VALUE_BYTES, {60'd0, forbu_pkg::MAX_FOR_BYTES});
      write_reg(forbu_pkg::REG_BASE, '1);
      write_reg(forbu_pkg::REG_BLOCK_ROWS, 64'd1);
      send_byte(8'h02, 0);
      repeat (3) send_byte(8'h00, 0);
      drain();

      // One-bit offsets: eight values per beat. The receiver holds off for
      // a long stretch while beats keep coming, so the queue fills and
      // req_tready drops. Plain mode must ignore the all-ones base.
      write_reg(forbu_pkg::REG_MODE, 64'd0);
      write_reg(forbu_pkg::REG_VALUE_BYTES, 64'd1);
      write_reg(forbu_pkg::REG_OFFSET_WIDTH, 64'd1);
      write_reg(forbu_pkg::REG_BLOCK_ROWS, 64'd64);
      hold_request <= ~hold_request;
      @(posedge clock);
      wait (hold_ack == hold_request);
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_byte(8'hA5, 0);
      send_byte(8'h5A, 0);
      send_byte(8'h01, 0);
      send_byte(8'h80, 0);
      send_byte(8'h3C, 0);
      send_byte(8'hC3, 0);
      drain();

      // Bad value widths: zero, above the plain limit, above the FOR limit.
      write_reg(forbu_pkg::REG_VALUE_BYTES, 64'd0);
      send_byte(8'h55, 0);
      drain();
      write_reg(forbu_pkg::REG_VALUE_BYTES, 64'd5);
      send_byte(8'hAA, 0);
      drain();
      write_reg(forbu_pkg::REG_MODE, 64'd1);
      write_reg(forbu_pkg::REG_VALUE_BYTES, 64'd9);
      send_byte(8'h0F, 0);
      drain();
      // both widths bad: the value width error wins
      write_reg(forbu_pkg::REG_OFFSET_WIDTH, 64'd0);
      send_byte(8'hF0, 0);
      drain();
      // bad offset widths alone: zero, then just above the limit
      write_reg(forbu_pkg::REG_VALUE_BYTES, {60'd0, forbu_pkg::MAX_FOR_BYTES});
      send_byte(8'h81, 0);
      drain();
      write_reg(forbu_pkg::REG_OFFSET_WIDTH, {58'd0, forbu_pkg::MAX_OFFSET_WIDTH + 6'd1});
      send_byte(8'h7E, 0);
      drain();

      // a write past the last register changes nothing
      write_reg(REG_UNUSED_FIRST, '1);

      while (payload_beats < RANDOM_BEATS) random_block();

      drain();
      if (mismatch_count == 0 && values_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
